>>> rtl/qvr_pkg.sv
// shared widths, payload types and term tables for the quaternion point rotator
`timescale 1ns / 1ps
package qvr_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int QUAT_WIDTH  = 16;
	localparam int QFRAC       = QUAT_WIDTH - 2;

	// first product q * (0, v)
	localparam int P1_W = COORD_WIDTH + QUAT_WIDTH;
	localparam int S1_W = P1_W + 3;
	localparam int T_W  = S1_W - QFRAC;
	// second product t * conj(q)
	localparam int P2_W = T_W + QUAT_WIDTH;
	localparam int S2_W = P2_W + 3;
	localparam int R_W  = S2_W - QFRAC;

	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W  = QUAT_WIDTH;

	localparam logic [CFG_INDEX_W-1:0] REG_QUAT_W = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_QUAT_X = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] REG_QUAT_Y = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] REG_QUAT_Z = CFG_INDEX_W'(3);

	localparam logic [QUAT_WIDTH-1:0] QUAT_ONE = QUAT_WIDTH'(1) << QFRAC;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] point_x;
		logic signed [COORD_WIDTH-1:0] point_y;
		logic signed [COORD_WIDTH-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] rotated_x;
		logic signed [COORD_WIDTH-1:0] rotated_y;
		logic signed [COORD_WIDTH-1:0] rotated_z;
		logic                          saturated;
	} rotated_t;

	// quaternion component select: 0 w, 1 x, 2 y, 3 z
	// t[c] = sum over n of +/- q[T1_QSEL[c][n]] * p[T1_PSEL[c][n]]
	localparam logic [1:0] T1_QSEL [4][3] = '{
		'{2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd2, 2'd3},
		'{2'd0, 2'd1, 2'd3},
		'{2'd0, 2'd1, 2'd2}
	};
	localparam logic [1:0] T1_PSEL [4][3] = '{
		'{2'd0, 2'd1, 2'd2},
		'{2'd0, 2'd2, 2'd1},
		'{2'd1, 2'd2, 2'd0},
		'{2'd2, 2'd1, 2'd0}
	};
	localparam logic T1_NEG [4][3] = '{
		'{1'b1, 1'b1, 1'b1},
		'{1'b0, 1'b0, 1'b1},
		'{1'b0, 1'b1, 1'b0},
		'{1'b0, 1'b0, 1'b1}
	};

	// vector part of t * conj(q), conjugate sign folded into the table
	// r[c] = sum over n of +/- t[T2_TSEL[c][n]] * q[T2_QSEL[c][n]]
	localparam logic [1:0] T2_TSEL [3][4] = '{
		'{2'd1, 2'd0, 2'd2, 2'd3},
		'{2'd2, 2'd0, 2'd1, 2'd3},
		'{2'd3, 2'd0, 2'd1, 2'd2}
	};
	localparam logic [1:0] T2_QSEL [3][4] = '{
		'{2'd0, 2'd1, 2'd3, 2'd2},
		'{2'd0, 2'd2, 2'd3, 2'd1},
		'{2'd0, 2'd3, 2'd2, 2'd1}
	};
	localparam logic T2_NEG [3][4] = '{
		'{1'b0, 1'b1, 1'b1, 1'b0},
		'{1'b0, 1'b1, 1'b0, 1'b1},
		'{1'b0, 1'b1, 1'b1, 1'b0}
	};

endpackage

>>> rtl/quaternion_vector_rotate.sv
// Rotates a stream of Q16.16 points by a configured Q2.14 quaternion as
// q * (0, v) * conj(q). One point can enter every cycle while out_stall is low;
// it goes through a multiply rank and an add-and-round rank for each of the
// two Hamilton products, then a saturation rank that is also the output register.
// Stages only hold while the next one is full and held, so bubbles are squeezed
// out under output stall. The quaternion is used as written (not normalized),
// resets to the identity and must only be rewritten while the pipe is empty.
// Each product rounds to nearest with ties toward plus infinity; saturated
// flags any clamped coordinate.
`timescale 1ns / 1ps
module quaternion_vector_rotate (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [qvr_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  logic [qvr_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  qvr_pkg::point_t                     in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output qvr_pkg::rotated_t                   out_data
);

	localparam int CW  = qvr_pkg::COORD_WIDTH;
	localparam int QW  = qvr_pkg::QUAT_WIDTH;
	localparam int FR  = qvr_pkg::QFRAC;
	localparam int P1W = qvr_pkg::P1_W;
	localparam int S1W = qvr_pkg::S1_W;
	localparam int TW  = qvr_pkg::T_W;
	localparam int P2W = qvr_pkg::P2_W;
	localparam int S2W = qvr_pkg::S2_W;
	localparam int RW  = qvr_pkg::R_W;

	localparam logic signed [S1W-1:0] HALF1 = S1W'(1) << (FR - 1);
	localparam logic signed [S2W-1:0] HALF2 = S2W'(1) << (FR - 1);
	localparam logic signed [CW-1:0]  MAX_C = {1'b0, {(CW-1){1'b1}}};
	localparam logic signed [CW-1:0]  MIN_C = {1'b1, {(CW-1){1'b0}}};

	logic signed [QW-1:0] quat_q [4];

	logic signed [P1W-1:0] prod1_s1 [4][3];
	logic signed [TW-1:0]  t_s2 [4];
	logic signed [P2W-1:0] prod2_s3 [3][4];
	logic signed [RW-1:0]  r_s4 [3];
	qvr_pkg::rotated_t     out_s5;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_s5;

	logic signed [CW-1:0]  pnt [3];
	logic signed [S1W-1:0] sum1 [4];
	logic signed [S2W-1:0] sum2 [3];
	logic signed [P1W-1:0] prod1 [4][3];
	logic signed [P2W-1:0] prod2 [3][4];
	logic [CW-1:0]         sat_val [3];
	logic [2:0]            sat_flag;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q[0] <= qvr_pkg::QUAT_ONE;
			quat_q[1] <= '0;
			quat_q[2] <= '0;
			quat_q[3] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				qvr_pkg::REG_QUAT_W: quat_q[0] <= cfg_data;
				qvr_pkg::REG_QUAT_X: quat_q[1] <= cfg_data;
				qvr_pkg::REG_QUAT_Y: quat_q[2] <= cfg_data;
				qvr_pkg::REG_QUAT_Z: quat_q[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage takes new data when it is empty or its content moves on
	assign rdy_s5   = !v_s5 || !out_stall;
	assign rdy_s4   = !v_s4 || rdy_s5;
	assign rdy_s3   = !v_s3 || rdy_s4;
	assign rdy_s2   = !v_s2 || rdy_s3;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= in_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_s5) v_s5 <= v_s4;
		end
	end

	// stage 1: the twelve products of q * (0, v)
	assign pnt[0] = in_data.point_x;
	assign pnt[1] = in_data.point_y;
	assign pnt[2] = in_data.point_z;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			for (int n = 0; n < 3; n++) begin
				prod1[c][n] = quat_q[qvr_pkg::T1_QSEL[c][n]] * pnt[qvr_pkg::T1_PSEL[c][n]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) prod1_s1 <= prod1;
	end

	// stage 2: signed sums, round back to the coordinate scale
	always_comb begin
		for (int c = 0; c < 4; c++) begin
			sum1[c] = HALF1;
			for (int n = 0; n < 3; n++) begin
				if (qvr_pkg::T1_NEG[c][n]) sum1[c] = sum1[c] - S1W'(prod1_s1[c][n]);
				else sum1[c] = sum1[c] + S1W'(prod1_s1[c][n]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			for (int c = 0; c < 4; c++) t_s2[c] <= sum1[c][S1W-1:FR];
		end
	end

	// stage 3: the twelve products feeding the vector part of t * conj(q)
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int n = 0; n < 4; n++) begin
				prod2[c][n] = t_s2[qvr_pkg::T2_TSEL[c][n]] * quat_q[qvr_pkg::T2_QSEL[c][n]];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3) prod2_s3 <= prod2;
	end

	// stage 4: signed sums and rounding
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum2[c] = HALF2;
			for (int n = 0; n < 4; n++) begin
				if (qvr_pkg::T2_NEG[c][n]) sum2[c] = sum2[c] - S2W'(prod2_s3[c][n]);
				else sum2[c] = sum2[c] + S2W'(prod2_s3[c][n]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			for (int c = 0; c < 3; c++) r_s4[c] <= sum2[c][S2W-1:FR];
		end
	end

	// stage 5: clamp to the coordinate range, fits when all top bits agree
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if ((&r_s4[c][RW-1:CW-1]) || !(|r_s4[c][RW-1:CW-1])) begin
				sat_val[c]  = r_s4[c][CW-1:0];
				sat_flag[c] = 1'b0;
			end else begin
				sat_val[c]  = r_s4[c][RW-1] ? MIN_C : MAX_C;
				sat_flag[c] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) begin
			out_s5.rotated_x <= sat_val[0];
			out_s5.rotated_y <= sat_val[1];
			out_s5.rotated_z <= sat_val[2];
			out_s5.saturated <= |sat_flag;
		end
	end

	assign out_valid = v_s5;
	assign out_data  = out_s5;

endmodule

>>> sim/tb_top.sv
// self-checking testbench for quaternion_vector_rotate with queue-fed driver and monitor
`timescale 1ns / 1ps
module tb_top;

	localparam int COORD_WIDTH = qvr_pkg::COORD_WIDTH;
	localparam int QUAT_WIDTH = qvr_pkg::QUAT_WIDTH;
	localparam int QFRAC = qvr_pkg::QFRAC;
	localparam int CFG_INDEX_W = qvr_pkg::CFG_INDEX_W;
	localparam int CFG_DATA_W = qvr_pkg::CFG_DATA_W;
	localparam logic [QUAT_WIDTH-1:0] QUAT_ONE = qvr_pkg::QUAT_ONE;

	localparam int REG_COUNT = 4;
	localparam int IDLE_LIMIT = 4000;
	localparam int DRAIN_EVERY = 300;
	localparam int RANDOM_PHASES = 8;
	localparam int PHASE_POINTS = 210;
	localparam longint COORD_MAX = (longint'(1) << (COORD_WIDTH - 1)) - 1;
	localparam longint COORD_MIN = -COORD_MAX - 1;
	localparam longint ROUND_HALF = longint'(1) << (QFRAC - 1);
	localparam logic signed [COORD_WIDTH-1:0] PT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
	localparam logic signed [COORD_WIDTH-1:0] PT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic signed [COORD_WIDTH-1:0] PT_UNIT = COORD_WIDTH'(65536);
	localparam logic [QUAT_WIDTH-1:0] QUAT_MAX = {1'b0, {(QUAT_WIDTH-1){1'b1}}};
	localparam logic [QUAT_WIDTH-1:0] QUAT_MIN = {1'b1, {(QUAT_WIDTH-1){1'b0}}};
	localparam logic [QUAT_WIDTH-1:0] QUAT_HALF = QUAT_ONE >> 1;
	localparam logic [QUAT_WIDTH-1:0] QUAT_COS45 = QUAT_WIDTH'(11585);

	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_RUNS, STALL_TOGGLE} stall_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	qvr_pkg::point_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	qvr_pkg::rotated_t out_data;

	quaternion_vector_rotate dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// quaternion as the block should currently hold it
	logic signed [QUAT_WIDTH-1:0] quat_shadow [REG_COUNT];

	qvr_pkg::point_t point_queue [$];
	qvr_pkg::rotated_t rotation_expected [$];
	int issued_total = 0;
	int accepted_total = 0;
	int mismatch_count = 0;
	int idle_cycles = 0;

	function automatic longint round_back(longint s);
		return (s + ROUND_HALF) >>> QFRAC;
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(input longint v,
			output bit hit);
		hit = 1'b0;
		if (v > COORD_MAX) begin
			hit = 1'b1;
			return PT_MAX;
		end
		if (v < COORD_MIN) begin
			hit = 1'b1;
			return PT_MIN;
		end
		return COORD_WIDTH'(v);
	endfunction

	// q * (0, p) * conj(q), each product rounded back to coordinate scale
	function automatic qvr_pkg::rotated_t rotate_point(qvr_pkg::point_t pt);
		longint q0, q1, q2, q3, px, py, pz, t0, t1, t2, t3, r1, r2, r3;
		bit hx, hy, hz;
		qvr_pkg::rotated_t res;
		q0 = quat_shadow[qvr_pkg::REG_QUAT_W[1:0]];
		q1 = quat_shadow[qvr_pkg::REG_QUAT_X[1:0]];
		q2 = quat_shadow[qvr_pkg::REG_QUAT_Y[1:0]];
		q3 = quat_shadow[qvr_pkg::REG_QUAT_Z[1:0]];
		px = pt.point_x;
		py = pt.point_y;
		pz = pt.point_z;
		t0 = round_back(-q1 * px - q2 * py - q3 * pz);
		t1 = round_back(q0 * px + q2 * pz - q3 * py);
		t2 = round_back(q0 * py - q1 * pz + q3 * px);
		t3 = round_back(q0 * pz + q1 * py - q2 * px);
		r1 = round_back(-t0 * q1 + t1 * q0 - t2 * q3 + t3 * q2);
		r2 = round_back(-t0 * q2 + t1 * q3 + t2 * q0 - t3 * q1);
		r3 = round_back(-t0 * q3 - t1 * q2 + t2 * q1 + t3 * q0);
		res.rotated_x = clamp_coord(r1, hx);
		res.rotated_y = clamp_coord(r2, hy);
		res.rotated_z = clamp_coord(r3, hz);
		res.saturated = hx | hy | hz;
		return res;
	endfunction

	function automatic logic signed [COORD_WIDTH-1:0] random_coord();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 4)
			return COORD_WIDTH'($urandom);
		if (pick < 8)
			return COORD_WIDTH'($urandom_range(0, 1 << 22)) - COORD_WIDTH'(1 << 21);
		if (pick == 8) begin
			case ($urandom_range(0, 4))
				0: return PT_MAX;
				1: return PT_MIN;
				2: return '0;
				3: return COORD_WIDTH'(1);
				default: return -COORD_WIDTH'(1);
			endcase
		end
		// top two bits picked independently at random over random lower bits
		return {$urandom_range(0, 1) == 1, 1'b1 ^ ($urandom_range(0, 1) == 1),
			(COORD_WIDTH-2)'($urandom)};
	endfunction

	task automatic push_point(logic signed [COORD_WIDTH-1:0] x,
			logic signed [COORD_WIDTH-1:0] y, logic signed [COORD_WIDTH-1:0] z);
		qvr_pkg::point_t pt;
		pt.point_x = x;
		pt.point_y = y;
		pt.point_z = z;
		point_queue.push_back(pt);
		issued_total++;
	endtask

	task automatic wait_drained();
		while (accepted_total != issued_total || rotation_expected.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < REG_COUNT)
			quat_shadow[idx[1:0]] = val;
	endtask

	task automatic load_quat(logic [QUAT_WIDTH-1:0] w, logic [QUAT_WIDTH-1:0] x,
			logic [QUAT_WIDTH-1:0] y, logic [QUAT_WIDTH-1:0] z);
		wait_drained();
		write_reg(qvr_pkg::REG_QUAT_W, w);
		write_reg(qvr_pkg::REG_QUAT_X, x);
		write_reg(qvr_pkg::REG_QUAT_Y, y);
		write_reg(qvr_pkg::REG_QUAT_Z, z);
	endtask

	task automatic flag_error(string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("error at %0t: %s", $realtime, msg);
	endtask

	// sender: bursts of transfers separated by random gaps, plus occasional full drains
	int burst_left = 0;
	int gap_left = 0;
	bit draining = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
			burst_left = 0;
			gap_left = 0;
			draining = 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				rotation_expected.push_back(rotate_point(in_data));
				accepted_total++;
				if (accepted_total % DRAIN_EVERY == DRAIN_EVERY / 2)
					draining = 1'b1;
			end else if (draining && rotation_expected.size() == 0) begin
				draining = 1'b0;
			end
			if (!(in_valid && in_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (draining || point_queue.size() == 0) begin
					in_valid <= 1'b0;
				end else begin
					in_valid <= 1'b1;
					in_data <= point_queue.pop_front();
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
		end
	end

	// receiver stall pattern, switching style after each randomly long run
	stall_mode_t stall_mode = STALL_NONE;
	int mode_left = 0;
	int stall_run = 0;
	bit stall_hold = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_mode = STALL_NONE;
			mode_left = 0;
			stall_run = 0;
			stall_hold = 1'b0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(64, 512);
			end else begin
				mode_left--;
			end
			case (stall_mode)
				STALL_NONE: out_stall <= 1'b0;
				STALL_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
				STALL_RUNS: begin
					if (stall_run == 0) begin
						stall_hold = ~stall_hold;
						stall_run = stall_hold ? $urandom_range(1, 24) : $urandom_range(1, 12);
					end else begin
						stall_run--;
					end
					out_stall <= stall_hold;
				end
				default: out_stall <= ~out_stall;
			endcase
		end
	end

	// result checker
	always @(posedge clk) begin
		qvr_pkg::rotated_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (rotation_expected.size() == 0) begin
				flag_error($sformatf("result transfer with no point pending: %h", out_data));
			end else begin
				want = rotation_expected.pop_front();
				if (out_data.rotated_x !== want.rotated_x)
					flag_error($sformatf("rotated_x expected %0d got %0d",
						want.rotated_x, out_data.rotated_x));
				if (out_data.rotated_y !== want.rotated_y)
					flag_error($sformatf("rotated_y expected %0d got %0d",
						want.rotated_y, out_data.rotated_y));
				if (out_data.rotated_z !== want.rotated_z)
					flag_error($sformatf("rotated_z expected %0d got %0d",
						want.rotated_z, out_data.rotated_z));
				if (out_data.saturated !== want.saturated)
					flag_error($sformatf("saturated expected %0b got %0b",
						want.saturated, out_data.saturated));
			end
		end
	end

	// watchdog: no transfer for too long while work is outstanding
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else if (accepted_total != issued_total || rotation_expected.size() != 0)
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("quaternion_vector_rotate: mismatch");
				$finish;
			end
		end
	end

	initial begin
		int unsigned pick;
		quat_shadow[qvr_pkg::REG_QUAT_W[1:0]] = QUAT_ONE;
		quat_shadow[qvr_pkg::REG_QUAT_X[1:0]] = '0;
		quat_shadow[qvr_pkg::REG_QUAT_Y[1:0]] = '0;
		quat_shadow[qvr_pkg::REG_QUAT_Z[1:0]] = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity after reset
		push_point('0, '0, '0);
		push_point(PT_MAX, PT_MIN, COORD_WIDTH'(1));
		push_point(PT_MIN, PT_MAX, -COORD_WIDTH'(1));
		push_point(32'sh12345678, -32'sh0abcdef0, 32'sh7fff0000);

		// half scale: rounding ties go toward plus infinity
		load_quat(QUAT_HALF, '0, '0, '0);
		push_point(COORD_WIDTH'(1), -COORD_WIDTH'(1), COORD_WIDTH'(3));
		push_point(-COORD_WIDTH'(3), COORD_WIDTH'(5), -COORD_WIDTH'(5));

		// quarter turn about z
		load_quat(QUAT_COS45, '0, '0, QUAT_COS45);
		push_point(PT_UNIT, '0, '0);
		push_point('0, PT_UNIT, -PT_UNIT);

		// largest components: heavy scaling, saturation
		load_quat(QUAT_MAX, QUAT_MAX, QUAT_MAX, QUAT_MAX);
		push_point(PT_MAX, PT_MAX, PT_MAX);
		push_point(PT_MIN, PT_MIN, PT_MIN);
		push_point(COORD_WIDTH'(1), COORD_WIDTH'(1), COORD_WIDTH'(1));

		load_quat(QUAT_MIN, QUAT_MIN, QUAT_MIN, QUAT_MIN);
		push_point(PT_MAX, PT_MIN, PT_MAX);
		push_point(PT_UNIT, '0, '0);
		push_point('0, '0, '0);

		// zero quaternion collapses every point, writes past the last register are ignored
		load_quat('0, '0, '0, '0);
		push_point(PT_MAX, PT_MIN, PT_MAX);
		wait_drained();
		write_reg(CFG_INDEX_W'(REG_COUNT), QUAT_MAX);
		write_reg({CFG_INDEX_W{1'b1}}, QUAT_ONE);
		push_point(PT_MAX, PT_MAX, PT_MAX);

		// negative scalar alone scales by four
		load_quat(QUAT_MIN, '0, '0, '0);
		push_point(32'sh20000000, -32'sh20000000, COORD_WIDTH'(1));

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			pick = phase % 3;
			if (pick == 0)
				load_quat(QUAT_WIDTH'($urandom), QUAT_WIDTH'($urandom),
					QUAT_WIDTH'($urandom), QUAT_WIDTH'($urandom));
			else if (pick == 1)
				load_quat(QUAT_WIDTH'($urandom_range(0, 2 * QUAT_ONE) - QUAT_ONE),
					QUAT_WIDTH'($urandom_range(0, QUAT_ONE) - QUAT_HALF),
					QUAT_WIDTH'($urandom_range(0, QUAT_ONE) - QUAT_HALF),
					QUAT_WIDTH'($urandom_range(0, QUAT_ONE) - QUAT_HALF));
			else
				load_quat(QUAT_WIDTH'($urandom_range(0, 64) - 32),
					QUAT_WIDTH'($urandom_range(0, 64) - 32),
					QUAT_WIDTH'($urandom), QUAT_WIDTH'($urandom_range(0, 64) - 32));
			if ($urandom_range(0, 1) == 1)
				write_reg(CFG_INDEX_W'($urandom_range(REG_COUNT, (1 << CFG_INDEX_W) - 1)),
					CFG_DATA_W'($urandom));
			for (int n = 0; n < PHASE_POINTS; n++)
				push_point(random_coord(), random_coord(), random_coord());
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (rotation_expected.size() != 0)
			flag_error("expected results left over at end of run");
		if (mismatch_count == 0)
			$display("quaternion_vector_rotate: match");
		else
			$display("quaternion_vector_rotate: mismatch");
		$finish;
	end

endmodule

>>> quaternion_vector_rotate.f
rtl/qvr_pkg.sv
rtl/quaternion_vector_rotate.sv
sim/tb_top.sv
